/* rtl/sparse_table_range_max_core_assert.svh */
// Assertion macros shared by the range-maximum RTL.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef SPARSE_TABLE_RANGE_MAX_CORE_ASSERT_SVH
`define SPARSE_TABLE_RANGE_MAX_CORE_ASSERT_SVH

// Checks a property on every rising clock edge outside reset.
`define STRMQ_AST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks that one condition implies another in the same cycle.
`define STRMQ_AST_IMP(lbl, ante, cons, msg) \
	`STRMQ_AST(lbl, (ante) |-> (cons), msg)

`endif

/* rtl/strmq_pkg.sv */
// Package for the sparse-table range-maximum engine: field widths, item codes
// and the priority encoder. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package strmq_pkg;

	localparam int FUNC_W   = 2;
	localparam int INDEX_W  = 10;
	localparam int VALUE_W  = 32;
	localparam int LEN_W    = 11;
	localparam int POS_W    = 10;
	localparam int STATUS_W = 2;
	localparam int LOG_W    = 4;

	localparam logic [FUNC_W-1:0] FUNC_LOAD  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_BUILD = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_QUERY = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNBUILT = 2'd2;

	typedef logic [FUNC_W-1:0]   func_t;
	typedef logic [STATUS_W-1:0] status_t;

	function automatic logic [LOG_W-1:0] floor_log2(input logic [LEN_W-1:0] v);
		logic [LOG_W-1:0] r;
		r = '0;
		for (int b = 1; b < LEN_W; b++) begin
			if (v[b]) begin
				r = LOG_W'(b);
			end
		end
		return r;
	endfunction

endpackage

`default_nettype wire

/* rtl/strmq_if.sv */
// Valid/ready channel interfaces for the range-maximum engine: one for input
// items and one for results. They depend on strmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface strmq_in_if;
	import strmq_pkg::*;

	logic                      valid;
	logic                      ready;
	func_t                     func;
	logic [INDEX_W-1:0]        index;
	logic signed [VALUE_W-1:0] value;
	logic [LEN_W-1:0]          length;
	logic [POS_W-1:0]          left;
	logic [POS_W-1:0]          right;

	modport source (output valid, func, index, value, length, left, right, input ready);
	modport sink   (input valid, func, index, value, length, left, right, output ready);
endinterface

interface strmq_out_if;
	import strmq_pkg::*;

	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] max_value;
	status_t                   status;

	modport source (output valid, max_value, status, input ready);
	modport sink   (input valid, max_value, status, output ready);
endinterface

`default_nettype wire

/* rtl/strmq_ram.sv */
// Generic simple dual-port RAM with one write port and one registered read port.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module strmq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

`default_nettype wire

/* rtl/strmq_cmp.sv */
// Shared signed compare unit: holds the first operand read from the table and
// returns the larger of it and the current read data. It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

module strmq_cmp #(
	parameter int DATA_WIDTH = 32
) (
	input  wire logic                         clk,
	input  wire logic                         load_a,
	input  wire logic signed [DATA_WIDTH-1:0] rd_data,
	output logic signed      [DATA_WIDTH-1:0] larger
);

	logic signed [DATA_WIDTH-1:0] a_q;

	always_ff @(posedge clk) begin
		if (load_a) begin
			a_q <= rd_data;
		end
	end

	assign larger = (rd_data > a_q) ? rd_data : a_q;

endmodule

`default_nettype wire

/* rtl/sparse_table_range_max_core.sv */
// Top level of the sparse-table range-maximum engine: sequencer, table RAM and
// shared compare unit. It depends on strmq_pkg, strmq_if, strmq_ram and strmq_cmp.
//
//   Channel  Dir  Payload                                   Handshake
//   req      in   func, index, value, length, left, right   valid/ready
//   rsp      out  max_value, status                         valid/ready
//
// A load item is written to the table as it is accepted. A build item passes through
// S_BRDA, S_BRDB and S_BWR for every table entry it fills, since each entry needs two
// reads through the single RAM read port. A query item holds the input while it passes
// through S_QCHK, S_QRDA, S_QRDB and S_QCMP, or only S_QCHK on error; the last registers its result.
// The table RAM is not cleared at reset; the state, count, built flag and result valid are.
// A result waits in the output register; a query holds in its last step until
// that register is free, and no new item is taken meanwhile.
`timescale 1ns / 1ps
`default_nettype none

module sparse_table_range_max_core #(
	parameter int MAX_ELEMENTS = 1024,
	parameter int LEVEL_COUNT  = 11,
	parameter int DATA_WIDTH   = 32
) (
	input  wire logic   clk,
	input  wire logic   arst_n,
	strmq_in_if.sink    req,
	strmq_out_if.source rsp
);
	import strmq_pkg::*;

	`include "sparse_table_range_max_core_assert.svh"

	localparam int AW    = $clog2(MAX_ELEMENTS);
	localparam int CW    = $clog2(MAX_ELEMENTS + 1);
	localparam int LW    = $clog2(LEVEL_COUNT);
	localparam int DEPTH = LEVEL_COUNT * MAX_ELEMENTS;
	localparam int RAW   = $clog2(DEPTH);
	localparam int SW    = LEVEL_COUNT + 1;
	localparam int KW    = ((SW > CW) ? SW : CW) + 1;
	localparam int EXW   = ((CW > LEN_W) ? CW : LEN_W) + 1;

	typedef enum logic [7:0] {
		S_IDLE = 8'b0000_0001,
		S_BRDA = 8'b0000_0010,
		S_BRDB = 8'b0000_0100,
		S_BWR  = 8'b0000_1000,
		S_QCHK = 8'b0001_0000,
		S_QRDA = 8'b0010_0000,
		S_QRDB = 8'b0100_0000,
		S_QCMP = 8'b1000_0000
	} state_t;

	state_t                 state_q;
	logic [CW-1:0]          count_q;
	logic                   built_q;
	logic                   out_valid_q;
	logic [LW-1:0]          lvl_q;
	logic [SW-1:0]          span_q;
	logic [AW-1:0]          i_q;
	logic [RAW-1:0]         base_q;
	logic [RAW-1:0]         addr_q;
	logic [RAW-1:0]         addr2_q;
	logic [POS_W-1:0]       left_q;
	logic [POS_W-1:0]       right_q;
	logic signed [VALUE_W-1:0] max_q;
	status_t                status_q;

	logic                   accept;
	logic                   out_free;
	logic                   emit;
	logic [CW-1:0]          n_sat;
	logic                   load_ok;
	logic                   wr_en;
	logic [RAW-1:0]         wr_addr;
	logic signed [DATA_WIDTH-1:0] wr_data;
	logic signed [DATA_WIDTH-1:0] wr_val;
	logic signed [DATA_WIDTH-1:0] rd_data;
	logic signed [DATA_WIDTH-1:0] larger;
	logic                   load_a;
	logic                   more;
	logic                   next_lvl;
	logic [RAW-1:0]         a_addr;
	logic [RAW-1:0]         b_addr;
	logic [RAW-1:0]         w_addr;
	logic                   q_err;
	status_t                q_status;
	logic [LEN_W-1:0]       q_len;
	logic [LOG_W-1:0]       j_raw;
	logic [LW-1:0]          j_c;
	logic [LEN_W-1:0]       q_span;
	logic [LEN_W-1:0]       q_second;
	logic [RAW-1:0]         q_base;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || rsp.ready;

	assign rsp.valid     = out_valid_q;
	assign rsp.max_value = max_q;
	assign rsp.status    = status_q;

	// Load and build decode.
	assign n_sat   = (EXW'(req.length) > EXW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS)
	                                                         : CW'(req.length);
	assign load_ok = 32'(req.index) < 32'(MAX_ELEMENTS);
	assign wr_val  = DATA_WIDTH'(req.value);

	// Build walk: entry i of level lvl from entries i and i + span/2 of level lvl-1.
	assign more     = (KW'(i_q) + KW'(span_q)) < KW'(count_q);
	assign next_lvl = ((({1'b0, lvl_q}) + 1'b1) < (LW + 1)'(LEVEL_COUNT))
	               && ((KW'(span_q) << 1) <= KW'(count_q));
	assign a_addr   = base_q + RAW'(i_q);
	assign b_addr   = a_addr + RAW'(span_q >> 1);
	assign w_addr   = a_addr + RAW'(MAX_ELEMENTS);

	// Query decode.
	assign q_len    = LEN_W'(right_q) - LEN_W'(left_q) + LEN_W'(1);
	assign j_raw    = floor_log2(q_len);
	assign j_c      = (32'(j_raw) >= 32'(LEVEL_COUNT)) ? LW'(LEVEL_COUNT - 1) : LW'(j_raw);
	assign q_span   = LEN_W'(1) << j_c;
	assign q_second = LEN_W'(right_q) + LEN_W'(1) - q_span;
	assign q_base   = RAW'(j_c) * RAW'(MAX_ELEMENTS);

	always_comb begin
		q_err    = 1'b1;
		q_status = ST_UNBUILT;
		if (built_q) begin
			if ((left_q > right_q) || (32'(right_q) >= 32'(count_q))) begin
				q_status = ST_RANGE;
			end else begin
				q_status = ST_OK;
				q_err    = 1'b0;
			end
		end
	end

	assign emit = ((state_q == S_QCHK) && q_err && out_free)
	           || ((state_q == S_QCMP) && out_free);

	assign load_a  = (state_q == S_BRDB) || (state_q == S_QRDB);
	assign wr_en   = (accept && (req.func == FUNC_LOAD) && load_ok) || (state_q == S_BWR);
	assign wr_addr = (state_q == S_BWR) ? w_addr : RAW'(req.index);
	assign wr_data = (state_q == S_BWR) ? larger : wr_val;

	strmq_ram #(
		.WIDTH (DATA_WIDTH),
		.DEPTH (DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	strmq_cmp #(
		.DATA_WIDTH (DATA_WIDTH)
	) u_cmp (
		.clk     (clk),
		.load_a  (load_a),
		.rd_data (rd_data),
		.larger  (larger)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			built_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.func)
							FUNC_LOAD: begin
								built_q <= 1'b0;
							end
							FUNC_BUILD: begin
								count_q <= n_sat;
								if (n_sat >= CW'(2)) begin
									built_q <= 1'b0;
									state_q <= S_BRDA;
								end else begin
									built_q <= 1'b1;
								end
							end
							FUNC_QUERY: begin
								state_q <= S_QCHK;
							end
							default: begin
							end
						endcase
					end
				end
				S_BRDA: state_q <= S_BRDB;
				S_BRDB: state_q <= S_BWR;
				S_BWR: begin
					if (more || next_lvl) begin
						state_q <= S_BRDA;
					end else begin
						built_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_QCHK: begin
					if (!q_err) begin
						state_q <= S_QRDA;
					end else if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				S_QRDA: state_q <= S_QRDB;
				S_QRDB: state_q <= S_QCMP;
				S_QCMP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					left_q  <= req.left;
					right_q <= req.right;
					lvl_q   <= LW'(1);
					span_q  <= SW'(2);
					i_q     <= '0;
					base_q  <= '0;
					addr_q  <= '0;
				end
			end
			S_BRDA: addr_q <= b_addr;
			S_BWR: begin
				if (more) begin
					i_q    <= i_q + AW'(1);
					addr_q <= a_addr + RAW'(1);
				end else if (next_lvl) begin
					lvl_q  <= lvl_q + LW'(1);
					span_q <= span_q << 1;
					i_q    <= '0;
					base_q <= base_q + RAW'(MAX_ELEMENTS);
					addr_q <= base_q + RAW'(MAX_ELEMENTS);
				end
			end
			S_QCHK: begin
				addr_q  <= q_base + RAW'(left_q);
				addr2_q <= q_base + RAW'(q_second);
			end
			S_QRDA: addr_q <= addr2_q;
			default: begin
			end
		endcase
		if (emit) begin
			if (state_q == S_QCHK) begin
				max_q    <= '0;
				status_q <= q_status;
			end else begin
				max_q    <= VALUE_W'(larger);
				status_q <= ST_OK;
			end
		end
	end

	`STRMQ_AST_IMP(a_wr_state, wr_en, (state_q == S_IDLE || state_q == S_BWR), "Table write outside load or build step")
	`STRMQ_AST_IMP(a_emit_free, emit, out_free, "Result written over an unread result")
	`STRMQ_AST_IMP(a_ok_built, (emit && state_q == S_QCMP), built_q, "Query answered from an unbuilt table")
	`STRMQ_AST_IMP(a_lvl_range, (state_q == S_BWR), (lvl_q != '0 && 32'(lvl_q) < 32'(LEVEL_COUNT)), "Build level out of range")
	`STRMQ_AST(a_busy_hold, (state_q != S_IDLE) |-> !req.ready, "Item taken while sequencer busy")

endmodule

`default_nettype wire

/* sim/tb_sparse_table_range_max_core.sv */
`timescale 1ns / 1ps

// Self-checking testbench for sparse_table_range_max_core. It drives loads, table builds and
// range-maximum queries with random idling on both channels and checks every result
// against a behavioural sparse table. It depends on strmq_pkg, strmq_if and the core RTL.

module tb_sparse_table_range_max_core;
	import strmq_pkg::*;

	localparam int ELEMS       = 1024;
	localparam int LEVELS      = 11;
	localparam int ITEM_TARGET = 1950;
	localparam int SQUEEZE_AT  = 150;
	localparam int SQUEEZE_LEN = 500;
	localparam int BIG_BUILDS  = 4;

	localparam func_t FUNC_UNUSED = 2'd3;

	typedef struct packed {
		func_t                     func;
		logic [INDEX_W-1:0]        index;
		logic signed [VALUE_W-1:0] value;
		logic [LEN_W-1:0]          length;
		logic [POS_W-1:0]          left;
		logic [POS_W-1:0]          right;
	} req_item_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] max_value;
		status_t                   status;
	} rmq_answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	strmq_in_if  req_ch ();
	strmq_out_if rsp_ch ();

	req_item_t drv_item = '0;
	logic      drv_valid = 1'b0;
	logic      rcv_ready = 1'b0;
	int        send_hold = 0;
	bit        send_calm = 1'b0;
	int        rcv_hold = 0;
	int        rcv_next = 0;
	bit        rcv_calm = 1'b0;

	req_item_t   req_backlog [$];
	rmq_answer_t due_answers [$];
	rmq_answer_t head;

	logic signed [VALUE_W-1:0] span_max [LEVELS][ELEMS];
	int unsigned               used_count = 0;
	bit                        is_built = 1'b0;

	int loads_taken = 0;
	int builds_taken = 0;
	int queries_taken = 0;
	int answers_seen = 0;
	int mismatches = 0;
	int big_builds = 0;

	assign req_ch.valid  = drv_valid;
	assign req_ch.func   = drv_item.func;
	assign req_ch.index  = drv_item.index;
	assign req_ch.value  = drv_item.value;
	assign req_ch.length = drv_item.length;
	assign req_ch.left   = drv_item.left;
	assign req_ch.right  = drv_item.right;
	assign rsp_ch.ready  = rcv_ready;

	sparse_table_range_max_core i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic logic signed [VALUE_W-1:0] larger(input logic signed [VALUE_W-1:0] a,
			input logic signed [VALUE_W-1:0] b);
		return ($signed(a) > $signed(b)) ? a : b;
	endfunction

	function automatic void track_table(input req_item_t it);
		rmq_answer_t res;
		int unsigned n;
		int unsigned half;
		int unsigned width;
		int unsigned lg;
		int unsigned second;
		case (it.func)
			FUNC_LOAD: begin
				span_max[0][it.index] = it.value;
				is_built = 1'b0;
				loads_taken++;
			end
			FUNC_BUILD: begin
				n = (it.length > ELEMS) ? ELEMS : it.length;
				used_count = n;
				for (int lvl = 1; lvl < LEVELS && (1 << lvl) <= n; lvl++) begin
					half = 1 << (lvl - 1);
					for (int i = 0; i + (1 << lvl) <= n; i++) begin
						span_max[lvl][i] = larger(span_max[lvl-1][i], span_max[lvl-1][i+half]);
					end
				end
				is_built = 1'b1;
				builds_taken++;
			end
			FUNC_QUERY: begin
				res.max_value = '0;
				if (!is_built) begin
					res.status = ST_UNBUILT;
				end else if (it.left > it.right || it.right >= used_count) begin
					res.status = ST_RANGE;
				end else begin
					width = it.right - it.left + 1;
					lg = 0;
					while (width > 1) begin
						width = width >> 1;
						lg++;
					end
					if (lg >= LEVELS) begin
						lg = LEVELS - 1;
					end
					second = it.right + 1 - (1 << lg);
					res.max_value = larger(span_max[lg][it.left], span_max[lg][second]);
					res.status = ST_OK;
				end
				due_answers.insert(due_answers.size(), res);
				queries_taken++;
			end
			default: begin
			end
		endcase
	endfunction

	function automatic req_item_t noise_item();
		req_item_t it;
		it.func   = func_t'($urandom_range(0, 3));
		it.index  = INDEX_W'($urandom());
		it.value  = $urandom();
		it.length = LEN_W'($urandom());
		it.left   = POS_W'($urandom());
		it.right  = POS_W'($urandom());
		return it;
	endfunction

	function automatic void append_item(input req_item_t it);
		req_backlog.insert(req_backlog.size(), it);
	endfunction

	function automatic void add_load(input int idx, input logic [VALUE_W-1:0] val);
		req_item_t it;
		it = noise_item();
		it.func = FUNC_LOAD;
		it.index = INDEX_W'(idx);
		it.value = val;
		append_item(it);
	endfunction

	function automatic void add_build(input int len);
		req_item_t it;
		it = noise_item();
		it.func = FUNC_BUILD;
		it.length = LEN_W'(len);
		append_item(it);
	endfunction

	function automatic void add_query(input int l, input int r);
		req_item_t it;
		it = noise_item();
		it.func = FUNC_QUERY;
		it.left = POS_W'(l);
		it.right = POS_W'(r);
		append_item(it);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_valid <= 1'b0;
			send_hold <= 0;
		end else begin
			if (drv_valid && req_ch.ready) begin
				track_table(drv_item);
			end
			if (!drv_valid || req_ch.ready) begin
				if (send_hold > 0) begin
					send_hold <= send_hold - 1;
					drv_valid <= 1'b0;
				end else if (req_backlog.size() > 0) begin
					drv_item <= req_backlog.pop_front();
					drv_valid <= 1'b1;
					if ($urandom_range(0, 49) == 0) begin
						send_calm = !send_calm;
					end
					send_hold <= send_calm ? 0 : $urandom_range(0, 10);
				end else begin
					drv_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcv_ready <= 1'b0;
			rcv_hold <= 0;
		end else if (rsp_ch.valid && rcv_ready) begin
			if (due_answers.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual max_value %0d status %0d",
					$time, $signed(rsp_ch.max_value), rsp_ch.status);
			end else begin
				head = due_answers.pop_front();
				if (rsp_ch.max_value !== head.max_value) begin
					mismatches++;
					$display("%0t: max_value mismatch, expected %0d, actual %0d", $time,
						$signed(head.max_value), $signed(rsp_ch.max_value));
				end
				if (rsp_ch.status !== head.status) begin
					mismatches++;
					$display("%0t: status mismatch, expected %0d, actual %0d", $time,
						head.status, rsp_ch.status);
				end
			end
			answers_seen++;
			if (answers_seen == SQUEEZE_AT) begin
				rcv_next = SQUEEZE_LEN;
			end else begin
				if ($urandom_range(0, 49) == 0) begin
					rcv_calm = !rcv_calm;
				end
				rcv_next = rcv_calm ? 0 : $urandom_range(0, 10);
			end
			rcv_hold <= rcv_next;
			rcv_ready <= (rcv_next == 0);
		end else if (rcv_hold > 0) begin
			rcv_hold <= rcv_hold - 1;
			rcv_ready <= (rcv_hold == 1);
		end else begin
			rcv_ready <= 1'b1;
		end
	end

	initial begin : stimulus
		int pick;
		int span;
		int used;
		int lo;
		logic [VALUE_W-1:0] val;
		req_item_t it;

		// Directed opening: unbuilt table, unused code, extreme values and bounds.
		add_query(0, 0);
		it = noise_item();
		it.func = FUNC_UNUSED;
		append_item(it);
		add_load(0, 32'h8000_0000);
		add_load(1, 32'h7FFF_FFFF);
		add_load(2, 32'hFFFF_FFFF);
		add_load(3, 32'h0000_0000);
		add_load(4, 32'h0000_0001);
		add_load(5, 32'h5555_5555);
		add_load(6, 32'hAAAA_AAAA);
		add_load(7, $urandom());
		add_load(1023, $urandom());
		add_query(0, 3);
		add_build(0);
		add_query(0, 0);
		add_build(8);
		add_query(0, 7);
		add_query(0, 0);
		add_query(7, 7);
		add_query(3, 2);
		add_query(0, 8);
		add_query(2, 6);
		add_query(1023, 1023);
		add_load(2, $urandom());
		add_query(0, 7);

		// Fill every position so that any later build reads only written entries.
		for (int i = 0; i < ELEMS; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				val = 32'h7FFF_FFFF;
			end else if (pick < 6) begin
				val = 32'h8000_0000;
			end else begin
				val = $urandom();
			end
			add_load(i, val);
		end
		add_build(2047);
		add_query(0, 1023);
		add_query(0, 1022);
		add_query(1, 1023);
		add_query(512, 1023);
		add_query($urandom_range(0, 1023), 1023);
		add_build(1024);
		add_query(0, 1023);
		add_query(1023, 1023);
		add_query(0, 1024 - 1);

		while (req_backlog.size() < ITEM_TARGET) begin
			if ($urandom_range(0, 99) < 80) begin
				pick = $urandom_range(0, 99);
				if (pick < 3 && big_builds < BIG_BUILDS) begin
					span = $urandom_range(257, 2047);
					big_builds++;
				end else if (pick < 10) begin
					span = $urandom_range(0, 1);
				end else begin
					span = $urandom_range(2, 64);
				end
				used = (span > ELEMS) ? ELEMS : span;
				repeat ($urandom_range(0, 6)) begin
					add_load($urandom_range(0, (used > 0) ? used - 1 : ELEMS - 1), $urandom());
				end
				add_build(span);
				repeat ($urandom_range(1, 8)) begin
					pick = $urandom_range(0, 99);
					if (pick < 8) begin
						add_load($urandom_range(0, ELEMS - 1), $urandom());
					end else if (used == 0 || pick < 25) begin
						add_query($urandom_range(0, ELEMS - 1), $urandom_range(0, ELEMS - 1));
					end else if (pick < 35) begin
						add_query(0, used - 1);
					end else begin
						lo = $urandom_range(0, used - 1);
						add_query(lo, $urandom_range(lo, used - 1));
					end
				end
			end else begin
				it = noise_item();
				if (it.func == FUNC_BUILD) begin
					it.length = LEN_W'($urandom_range(0, 64));
				end
				append_item(it);
			end
		end
		add_query(0, 0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (req_backlog.size() != 0 || drv_valid) begin
			@(posedge clk);
		end
		while (due_answers.size() != 0) begin
			@(posedge clk);
		end
		repeat (40) @(posedge clk);

		$display("Run covered %0d loads, %0d table builds and %0d range queries.",
			loads_taken, builds_taken, queries_taken);
		$display("%0d results compared, %0d mismatches found.", answers_seen, mismatches);
		if (mismatches == 0) begin
			$display("sparse_table_range_max_core verification clean");
		end else begin
			$display("sparse_table_range_max_core verification failed");
		end
		$finish;
	end

	initial begin
		#12_000_000;
		$display("Timed out with %0d items queued and %0d results outstanding.",
			req_backlog.size(), due_answers.size());
		$display("sparse_table_range_max_core verification failed");
		$finish;
	end

endmodule
